>>> hdl/frc_pkg.sv
// Shared types and constants of the framed command receiver.
package frc_pkg;

    // Header and payload sizes of the recognized messages, and the owed-answer limit.
    localparam logic [1:0]  HDR_LAST_BYTE = 2'd3;
    localparam logic [15:0] HS_PAYLOAD    = 16'd4;
    localparam logic [15:0] REQ_PAYLOAD   = 16'd12;
    localparam logic [7:0]  OWED_MAX      = 8'hFF;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HS_TYPE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REQ_TYPE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_VIDEO_CHAN  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUP_MAJOR   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD = 3'd5;

    // Input actions.
    typedef enum logic [1:0] {
        ACT_BYTE   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_ANSWER = 2'd2,
        ACT_OPEN   = 2'd3
    } frc_action_t;

    // Result event codes.
    typedef enum logic [3:0] {
        EV_ABSORBED  = 4'd0,
        EV_HS_OK     = 4'd1,
        EV_QUEUED    = 4'd2,
        EV_FULL      = 4'd3,
        EV_BAD_CHAN  = 4'd4,
        EV_SKIPPED   = 4'd5,
        EV_BAD_MAGIC = 4'd6,
        EV_SIZE      = 4'd7,
        EV_VERSION   = 4'd8,
        EV_CLOSED    = 4'd9,
        EV_POPPED    = 4'd10,
        EV_EMPTY     = 4'd11,
        EV_ANSWERED  = 4'd12,
        EV_NONE_OWED = 4'd13,
        EV_OPENED    = 4'd14
    } frc_event_t;

    // Configuration register contents.
    typedef struct packed {
        logic [7:0]  magic;
        logic [7:0]  hs_type;
        logic [7:0]  req_type;
        logic [7:0]  video_chan;
        logic [15:0] sup_major;
        logic [15:0] max_payload;
    } frc_cfg_t;

endpackage

>>> hdl/frc_ram.sv
// Generic single write port, single read port RAM with registered read.
module frc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; a read at a written address returns old data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/frc_cfg.sv
// Configuration register file of the framed command receiver.
module frc_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [frc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [frc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output frc_pkg::frc_cfg_t               cfg
);
    import frc_pkg::*;

    frc_cfg_t cfg_reg;
    frc_cfg_t cfg_next;

    // Writes are always taken; unknown indexes are ignored.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAGIC:       cfg_next.magic       = cfg_data[7:0];
                CFG_HS_TYPE:     cfg_next.hs_type     = cfg_data[7:0];
                CFG_REQ_TYPE:    cfg_next.req_type    = cfg_data[7:0];
                CFG_VIDEO_CHAN:  cfg_next.video_chan  = cfg_data[7:0];
                CFG_SUP_MAJOR:   cfg_next.sup_major   = cfg_data;
                CFG_MAX_PAYLOAD: cfg_next.max_payload = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic       <= 8'd0;
            cfg_reg.hs_type     <= 8'd1;
            cfg_reg.req_type    <= 8'd2;
            cfg_reg.video_chan  <= 8'd0;
            cfg_reg.sup_major   <= 16'd1;
            cfg_reg.max_payload <= 16'd1024;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/frc_core.sv
// Input register, message parser, request queue control and result register.
module frc_core #(
    parameter int QUEUE_DEPTH = 8,
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  frc_pkg::frc_cfg_t   cfg,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          action,
    input  logic [7:0]          data_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [3:0]          event_res,
    output logic [31:0]         queue_id,
    output logic [CW-1:0]       queued_count,
    output logic [7:0]          answers_owed,
    output logic                connected,
    output logic                ram_wr_en,
    output logic [AW-1:0]       ram_wr_addr,
    output logic [31:0]         ram_wr_data,
    output logic [AW-1:0]       ram_rd_addr,
    input  logic [31:0]         ram_rd_data
);
    import frc_pkg::*;

    localparam int SW = CW + 1;

    // Input stage.
    logic        in_valid_reg;
    frc_action_t action_reg;
    logic [7:0]  byte_reg;

    // Result stage.
    logic        out_valid_reg;
    frc_event_t  event_reg,  event_next;
    logic [31:0] id_reg,     id_next;

    // Connection and framing state.
    logic        link_reg,     link_next;
    logic [1:0]  hdr_cnt_reg,  hdr_cnt_next;
    logic        in_pay_reg,   in_pay_next;
    logic [15:0] remain_reg,   remain_next;
    logic [31:0] hword_reg,    hword_next;
    logic [31:0] cap_reg,      cap_next;
    logic [7:0]  first_reg,    first_next;

    // Queue and answer state.
    logic [AW-1:0] head_reg,   head_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [7:0]    owed_reg,   owed_next;

    // Bypass for a head entry written at the edge it was read.
    logic          byp_reg;
    logic [31:0]   byp_data_reg;

    logic          advance;
    logic          fire;
    logic          accept;
    logic          drop;
    logic [31:0]   hword_shift;
    logic [31:0]   cap_shift;
    logic [7:0]    first_sel;
    logic [SW-1:0] tail_sum;
    logic [AW-1:0] tail;
    logic [AW-1:0] head_inc;
    logic [31:0]   head_data;
    logic          queue_full;

    // Handshake: the result register frees up whenever it is empty or being taken.
    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;

    // Queue address arithmetic.
    assign tail_sum   = SW'(head_reg) + SW'(count_reg);
    assign tail       = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
                                                       : AW'(tail_sum);
    assign head_inc   = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_data  = byp_reg ? byp_data_reg : ram_rd_data;
    assign queue_full = (count_reg == CW'(QUEUE_DEPTH));

    // Shifted views of the current byte.
    assign hword_shift = {hword_reg[23:0], byte_reg};
    assign cap_shift   = {cap_reg[23:0], byte_reg};
    assign first_sel   = (remain_reg == hword_reg[15:0]) ? byte_reg : first_reg;

    // Per-item processing.
    always_comb
    begin
        link_next    = link_reg;
        hdr_cnt_next = hdr_cnt_reg;
        in_pay_next  = in_pay_reg;
        remain_next  = remain_reg;
        hword_next   = hword_reg;
        cap_next     = cap_reg;
        first_next   = first_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        owed_next    = owed_reg;
        event_next   = EV_ABSORBED;
        id_next      = '0;
        drop         = 1'b0;
        ram_wr_en    = 1'b0;

        if (fire)
        begin
            if (action_reg == ACT_OPEN)
            begin
                if (!link_reg)
                begin
                    drop       = 1'b1;
                    event_next = EV_OPENED;
                end
            end
            else if (!link_reg)
            begin
                event_next = EV_CLOSED;
            end
            else
            begin
                unique case (action_reg)
                    ACT_BYTE:
                    begin
                        if (!in_pay_reg)
                        begin
                            // Header byte.
                            hword_next   = hword_shift;
                            hdr_cnt_next = hdr_cnt_reg + 1'b1;
                            if (hdr_cnt_reg == HDR_LAST_BYTE)
                            begin
                                if (hword_shift[31:24] != cfg.magic)
                                begin
                                    drop       = 1'b1;
                                    event_next = EV_BAD_MAGIC;
                                end
                                else if (hword_shift[15:0] > cfg.max_payload)
                                begin
                                    drop       = 1'b1;
                                    event_next = EV_SIZE;
                                end
                                else
                                begin
                                    cap_next   = '0;
                                    first_next = '0;
                                    if (hword_shift[15:0] == 16'd0)
                                    begin
                                        event_next = EV_SKIPPED;
                                    end
                                    else
                                    begin
                                        in_pay_next = 1'b1;
                                        remain_next = hword_shift[15:0];
                                    end
                                end
                            end
                        end
                        else
                        begin
                            // Payload byte; the last one dispatches the message.
                            cap_next    = cap_shift;
                            first_next  = first_sel;
                            remain_next = remain_reg - 1'b1;
                            if (remain_reg == 16'd1)
                            begin
                                in_pay_next = 1'b0;
                                if (hword_reg[23:16] == cfg.hs_type
                                    && hword_reg[15:0] == HS_PAYLOAD)
                                begin
                                    if (cap_shift[31:16] > cfg.sup_major)
                                    begin
                                        drop       = 1'b1;
                                        event_next = EV_VERSION;
                                    end
                                    else
                                    begin
                                        if (owed_reg != OWED_MAX)
                                        begin
                                            owed_next = owed_reg + 1'b1;
                                        end
                                        event_next = EV_HS_OK;
                                    end
                                end
                                else if (hword_reg[23:16] == cfg.req_type
                                         && hword_reg[15:0] == REQ_PAYLOAD)
                                begin
                                    if (first_sel != cfg.video_chan)
                                    begin
                                        event_next = EV_BAD_CHAN;
                                    end
                                    else
                                    begin
                                        id_next = cap_shift;
                                        if (queue_full)
                                        begin
                                            event_next = EV_FULL;
                                        end
                                        else
                                        begin
                                            ram_wr_en  = 1'b1;
                                            count_next = count_reg + 1'b1;
                                            event_next = EV_QUEUED;
                                        end
                                    end
                                end
                                else
                                begin
                                    event_next = EV_SKIPPED;
                                end
                            end
                        end
                    end
                    ACT_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            event_next = EV_EMPTY;
                        end
                        else
                        begin
                            id_next    = head_data;
                            head_next  = head_inc;
                            count_next = count_reg - 1'b1;
                            event_next = EV_POPPED;
                        end
                    end
                    ACT_ANSWER:
                    begin
                        if (owed_reg != 8'd0)
                        begin
                            owed_next  = owed_reg - 1'b1;
                            event_next = EV_ANSWERED;
                        end
                        else
                        begin
                            event_next = EV_NONE_OWED;
                        end
                    end
                    default:
                    begin
                        event_next = EV_ABSORBED;
                    end
                endcase
            end

            // A dropped link clears all control state; opening raises the link again.
            if (drop)
            begin
                link_next    = (action_reg == ACT_OPEN);
                hdr_cnt_next = '0;
                in_pay_next  = 1'b0;
                head_next    = '0;
                count_next   = '0;
                owed_next    = '0;
            end
        end
    end

    // Queue memory ports: write at the tail, read ahead at the next head.
    assign ram_wr_addr = tail;
    assign ram_wr_data = cap_shift;
    assign ram_rd_addr = head_next;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            link_reg      <= 1'b0;
            hdr_cnt_reg   <= '0;
            in_pay_reg    <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            owed_reg      <= '0;
            byp_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            link_reg    <= link_next;
            hdr_cnt_reg <= hdr_cnt_next;
            in_pay_reg  <= in_pay_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            owed_reg    <= owed_next;
            byp_reg     <= ram_wr_en && (ram_wr_addr == ram_rd_addr);
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= frc_action_t'(action);
            byte_reg   <= data_byte;
        end
        if (fire)
        begin
            event_reg <= event_next;
            id_reg    <= id_next;
        end
        remain_reg   <= remain_next;
        hword_reg    <= hword_next;
        cap_reg      <= cap_next;
        first_reg    <= first_next;
        byp_data_reg <= ram_wr_data;
    end

    // Status outputs are captured with each result beat.
    logic [CW-1:0] count_out_reg;
    logic [7:0]    owed_out_reg;
    logic          link_out_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            count_out_reg <= count_next;
            owed_out_reg  <= owed_next;
            link_out_reg  <= link_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = event_reg;
    assign queue_id     = id_reg;
    assign queued_count = count_out_reg;
    assign answers_owed = owed_out_reg;
    assign connected    = link_out_reg;

endmodule

>>> hdl/framed_command_receiver.sv
// Top level of the framed command receiver.
//
// Takes one beat per clock while in_stall is low: a received stream byte or a
// control action (take a queued request, retire an owed handshake answer, open
// the connection), and returns exactly one result beat for each through the
// input register and then the result register. The parser checks magic and
// length on the fourth header byte, counts handshakes owed (saturating at
// 255), and queues 32-bit ids of video-channel requests in a QUEUE_DEPTH-entry
// FIFO held in a RAM with registered read; the next head entry is read ahead,
// so pops also run at one beat per clock. A bad magic, oversized payload or
// too-new handshake major version closes the link and clears the request queue
// and owed answers. The user must write the configuration registers (cfg port,
// always ready) only while no beat is in flight; the block does not check it.
module framed_command_receiver #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [frc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [frc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          action,
    input  logic [7:0]                          data_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [3:0]                          event_res,
    output logic [31:0]                         queue_id,
    output logic [$clog2(QUEUE_DEPTH + 1)-1:0]  queued_count,
    output logic [7:0]                          answers_owed,
    output logic                                connected
);
    import frc_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    frc_cfg_t      cfg;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [31:0]   ram_wr_data;
    logic [AW-1:0] ram_rd_addr;
    logic [31:0]   ram_rd_data;

    // Configuration registers.
    frc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Request id storage.
    frc_ram #(
        .WIDTH (32),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Parser and result pipeline.
    frc_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_res    (event_res),
        .queue_id     (queue_id),
        .queued_count (queued_count),
        .answers_owed (answers_owed),
        .connected    (connected),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data)
    );

endmodule

>>> bench/framed_command_receiver_tb.sv
// Self-checking testbench for the framed command receiver: directed cases, then random traffic.
`timescale 1ns / 100ps

module framed_command_receiver_tb;

    import frc_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int QD           = 8;
    localparam int CNT_W        = $clog2(QD + 1);
    localparam int HEADER_LEN   = 4;
    localparam int IDLE_PCT     = 24;
    localparam int SETTLE_TICKS = 4;
    localparam int TIMEOUT_NS   = 5_000_000;

    // Indexes that map to no register; writes to them must be ignored.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef logic [7:0] byte_q_t[$];

    // One expected result beat.
    typedef struct packed {
        frc_event_t       ev;
        logic [31:0]      id;
        logic [CNT_W-1:0] queued;
        logic [7:0]       owed;
        logic             conn;
    } beat_result_t;

    // Block ports.
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             action = ACT_BYTE;
    logic [7:0]             data_byte = 8'h00;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [3:0]             event_res;
    logic [31:0]            queue_id;
    logic [CNT_W-1:0]       queued_count;
    logic [7:0]             answers_owed;
    logic                   connected;

    // Shadow copy of the registers and of the receiver state.
    frc_cfg_t    cfg_shadow;
    logic        link_up;
    logic [16:0] rx_pos;
    logic [31:0] rx_header;
    logic [31:0] rx_tail;
    logic [7:0]  rx_channel;
    logic [31:0] req_slot [QD];
    logic [2:0]  req_head;
    logic [3:0]  req_level;
    logic [7:0]  owed_count;

    beat_result_t pending_results[$];

    bit send_idle_en = 1'b1;
    bit recv_idle_en = 1'b1;
    int beats_sent;
    int results_seen;
    int settings_loaded;
    int fail_count;

    framed_command_receiver #(
        .QUEUE_DEPTH (QD)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_res    (event_res),
        .queue_id     (queue_id),
        .queued_count (queued_count),
        .answers_owed (answers_owed),
        .connected    (connected)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // A dropped connection forgets everything but the settings and stored request ids.
    function automatic void drop_connection();
        link_up    = 1'b0;
        rx_pos     = '0;
        rx_header  = '0;
        rx_tail    = '0;
        rx_channel = '0;
        req_head   = '0;
        req_level  = '0;
        owed_count = '0;
    endfunction

    function automatic void reset_model();
        cfg_shadow.magic       = 8'h00;
        cfg_shadow.hs_type     = 8'h01;
        cfg_shadow.req_type    = 8'h02;
        cfg_shadow.video_chan  = 8'h00;
        cfg_shadow.sup_major   = 16'd1;
        cfg_shadow.max_payload = 16'd1024;
        foreach (req_slot[i])
            req_slot[i] = '0;
        drop_connection();
    endfunction

    // Acts on a complete message.
    function automatic frc_event_t dispatch_message(input logic [15:0] len,
                                                    output logic [31:0] id);
        logic [7:0] typ;
        typ    = rx_header[23:16];
        rx_pos = '0;
        id     = '0;
        if (typ == cfg_shadow.hs_type && len == HS_PAYLOAD)
        begin
            if (rx_tail[31:16] > cfg_shadow.sup_major)
            begin
                drop_connection();
                return EV_VERSION;
            end
            if (owed_count != OWED_MAX)
                owed_count = owed_count + 8'd1;
            return EV_HS_OK;
        end
        if (typ == cfg_shadow.req_type && len == REQ_PAYLOAD)
        begin
            if (rx_channel != cfg_shadow.video_chan)
                return EV_BAD_CHAN;
            id = rx_tail;
            if (req_level >= 4'(QD))
                return EV_FULL;
            // Eight slots: the 3-bit sum wraps like the queue does.
            req_slot[3'(req_head + req_level)] = rx_tail;
            req_level = req_level + 4'd1;
            return EV_QUEUED;
        end
        return EV_SKIPPED;
    endfunction

    // Header bytes are checked on the last one; payload keeps its first and last four bytes.
    function automatic frc_event_t absorb_byte(input logic [7:0] b, output logic [31:0] id);
        logic [15:0] len;
        id = '0;
        if (rx_pos < 17'(HEADER_LEN))
        begin
            rx_header = {rx_header[23:0], b};
            rx_pos    = rx_pos + 17'd1;
            if (rx_pos < 17'(HEADER_LEN))
                return EV_ABSORBED;
            if (rx_header[31:24] != cfg_shadow.magic)
            begin
                drop_connection();
                return EV_BAD_MAGIC;
            end
            len = rx_header[15:0];
            if (len > cfg_shadow.max_payload)
            begin
                drop_connection();
                return EV_SIZE;
            end
            rx_tail    = '0;
            rx_channel = '0;
            if (len == 16'd0)
                return dispatch_message(16'd0, id);
            return EV_ABSORBED;
        end
        len = rx_header[15:0];
        if (rx_pos == 17'(HEADER_LEN))
            rx_channel = b;
        rx_tail = {rx_tail[23:0], b};
        rx_pos  = rx_pos + 17'd1;
        if (rx_pos >= 17'(HEADER_LEN) + {1'b0, len})
            return dispatch_message(len, id);
        return EV_ABSORBED;
    endfunction

    // Works out the result of one accepted beat and queues it.
    function automatic void predict_beat(input frc_action_t act, input logic [7:0] b);
        beat_result_t r;
        logic [31:0]  id;
        frc_event_t   ev;
        id = '0;
        ev = EV_ABSORBED;
        if (act == ACT_OPEN)
        begin
            if (!link_up)
            begin
                drop_connection();
                link_up = 1'b1;
                ev      = EV_OPENED;
            end
        end
        else if (!link_up)
            ev = EV_CLOSED;
        else if (act == ACT_BYTE)
            ev = absorb_byte(b, id);
        else if (act == ACT_POP)
        begin
            if (req_level == 4'd0)
                ev = EV_EMPTY;
            else
            begin
                id        = req_slot[req_head];
                req_head  = req_head + 3'd1;
                req_level = req_level - 4'd1;
                ev        = EV_POPPED;
            end
        end
        else
        begin
            if (owed_count != 8'd0)
            begin
                owed_count = owed_count - 8'd1;
                ev         = EV_ANSWERED;
            end
            else
                ev = EV_NONE_OWED;
        end
        r.ev     = ev;
        r.id     = id;
        r.queued = CNT_W'(req_level);
        r.owed   = owed_count;
        r.conn   = link_up;
        pending_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Result checking and output stalls
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        beat_result_t want;
        results_seen++;
        if (pending_results.size() == 0)
        begin
            $error("result beat with nothing expected: event_res %0d", event_res);
            fail_count++;
        end
        else
        begin
            want = pending_results.pop_front();
            check_field("event_res", 32'(want.ev), 32'(event_res));
            check_field("queue_id", want.id, queue_id);
            check_field("queued_count", 32'(want.queued), 32'(queued_count));
            check_field("answers_owed", 32'(want.owed), 32'(answers_owed));
            check_field("connected", 32'(want.conn), 32'(connected));
        end
    endtask

    // Values read here are those the block saw at this edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_result();
        out_stall <= recv_idle_en && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Valid stays high after a beat; only an idle cycle or a drain lowers it.
    task automatic send_beat(input frc_action_t act, input logic [7:0] b);
        if (send_idle_en)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        action    <= act;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_beat(act, b);
        beats_sent++;
    endtask

    task automatic send_bytes(input byte_q_t body);
        foreach (body[i])
            send_beat(ACT_BYTE, body[i]);
    endtask

    task automatic send_header(input logic [7:0] mg, input logic [7:0] typ,
                               input logic [15:0] len);
        send_beat(ACT_BYTE, mg);
        send_beat(ACT_BYTE, typ);
        send_beat(ACT_BYTE, len[15:8]);
        send_beat(ACT_BYTE, len[7:0]);
    endtask

    task automatic send_frame(input logic [7:0] typ, input byte_q_t body);
        send_header(cfg_shadow.magic, typ, 16'(body.size()));
        send_bytes(body);
    endtask

    function automatic byte_q_t random_bytes(input int n);
        byte_q_t q;
        for (int i = 0; i < n; i++)
            q.push_back(8'($urandom));
        return q;
    endfunction

    // Handshake payload: major version big-endian, then a random minor.
    function automatic byte_q_t hs_body(input logic [15:0] major);
        byte_q_t q;
        q.push_back(major[15:8]);
        q.push_back(major[7:0]);
        q.push_back(8'($urandom));
        q.push_back(8'($urandom));
        return q;
    endfunction

    // Request payload: channel, seven filler bytes, then the id big-endian.
    function automatic byte_q_t req_body(input logic [7:0] chan, input logic [31:0] id);
        byte_q_t q;
        q.push_back(chan);
        for (int i = 0; i < 7; i++)
            q.push_back(8'($urandom));
        q.push_back(id[31:24]);
        q.push_back(id[23:16]);
        q.push_back(id[15:8]);
        q.push_back(id[7:0]);
        return q;
    endfunction

    // Holds the sender until every outstanding result is back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_MAGIC:       cfg_shadow.magic       = value[7:0];
            CFG_HS_TYPE:     cfg_shadow.hs_type     = value[7:0];
            CFG_REQ_TYPE:    cfg_shadow.req_type    = value[7:0];
            CFG_VIDEO_CHAN:  cfg_shadow.video_chan  = value[7:0];
            CFG_SUP_MAJOR:   cfg_shadow.sup_major   = value;
            CFG_MAX_PAYLOAD: cfg_shadow.max_payload = value;
            default:         ;
        endcase
    endtask

    // Byte-wide registers get random upper bits, which must be dropped.
    task automatic load_settings(input logic [7:0] mg, input logic [7:0] hs,
                                 input logic [7:0] rq, input logic [7:0] ch,
                                 input logic [15:0] sup, input logic [15:0] mp);
        drain_results();
        write_reg(CFG_SPARE_LO, 16'($urandom));
        write_reg(CFG_MAGIC, {8'($urandom), mg});
        write_reg(CFG_HS_TYPE, {8'($urandom), hs});
        write_reg(CFG_REQ_TYPE, {8'($urandom), rq});
        write_reg(CFG_VIDEO_CHAN, {8'($urandom), ch});
        write_reg(CFG_SUP_MAJOR, sup);
        write_reg(CFG_MAX_PAYLOAD, mp);
        write_reg(CFG_SPARE_HI, 16'($urandom));
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    // Mostly well-formed messages with random content, plus control actions,
    // broken headers, truncated messages and the odd pause for all results.
    task automatic run_traffic(input int count);
        int          stop_at;
        int          pick;
        logic [15:0] len;
        logic [15:0] major;
        logic [7:0]  typ;
        logic [7:0]  chan;
        stop_at = beats_sent + count;
        while (beats_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (!link_up)
            begin
                if (pick < 85)
                    send_beat(ACT_OPEN, 8'($urandom));
                else
                    send_beat(frc_action_t'($urandom_range(0, 2)), 8'($urandom));
            end
            else if (pick < 30)
            begin
                chan = ($urandom_range(0, 6) == 0) ? 8'($urandom) : cfg_shadow.video_chan;
                send_frame(cfg_shadow.req_type, req_body(chan, $urandom));
            end
            else if (pick < 50)
            begin
                if (cfg_shadow.sup_major != 16'hFFFF && $urandom_range(0, 9) == 0)
                    major = 16'($urandom_range(int'(cfg_shadow.sup_major) + 1, 65535));
                else
                    major = 16'($urandom_range(0, int'(cfg_shadow.sup_major)));
                send_frame(cfg_shadow.hs_type, hs_body(major));
            end
            else if (pick < 58)
            begin
                case ($urandom_range(0, 2))
                    0:       typ = cfg_shadow.hs_type;
                    1:       typ = cfg_shadow.req_type;
                    default: typ = 8'($urandom);
                endcase
                len = 16'($urandom_range(0, (cfg_shadow.max_payload < 16'd20) ?
                                            int'(cfg_shadow.max_payload) : 20));
                send_frame(typ, random_bytes(int'(len)));
            end
            else if (pick < 70)
                send_beat(ACT_POP, 8'($urandom));
            else if (pick < 80)
                send_beat(ACT_ANSWER, 8'($urandom));
            else if (pick < 83)
                send_beat(ACT_OPEN, 8'($urandom));
            else if (pick < 88)
                send_header(cfg_shadow.magic ^ 8'($urandom_range(1, 255)), 8'($urandom),
                            16'($urandom));
            else if (pick < 92)
            begin
                if (cfg_shadow.max_payload != 16'hFFFF)
                    send_header(cfg_shadow.magic, 8'($urandom),
                                16'($urandom_range(int'(cfg_shadow.max_payload) + 1, 65535)));
                else
                    send_beat(ACT_BYTE, 8'($urandom));
            end
            else if (pick < 96)
            begin
                // Message cut short: the next one runs into its payload.
                len = 16'($urandom_range(1, 16));
                send_header(cfg_shadow.magic, cfg_shadow.req_type, len);
                send_bytes(random_bytes($urandom_range(0, int'(len) - 1)));
            end
            else if (pick < 98)
                send_beat(ACT_BYTE, 8'($urandom));
            else
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // After reset the link is closed; opening twice only opens once.
    task automatic test_closed_link();
        send_beat(ACT_BYTE, 8'h00);
        send_beat(ACT_BYTE, 8'hFF);
        send_beat(ACT_POP, 8'h00);
        send_beat(ACT_ANSWER, 8'hFF);
        send_beat(ACT_OPEN, 8'h00);
        send_beat(ACT_OPEN, 8'hFF);
    endtask

    task automatic test_handshakes();
        send_frame(cfg_shadow.hs_type, hs_body(cfg_shadow.sup_major));
        send_frame(cfg_shadow.hs_type, hs_body(16'd0));
        send_beat(ACT_ANSWER, 8'h00);
        send_beat(ACT_ANSWER, 8'h00);
        send_beat(ACT_ANSWER, 8'h00);
        // A client newer than supported drops the link.
        send_frame(cfg_shadow.hs_type, hs_body(cfg_shadow.sup_major + 16'd1));
        send_beat(ACT_POP, 8'h00);
        send_beat(ACT_OPEN, 8'h00);
    endtask

    task automatic test_request_queue();
        send_frame(cfg_shadow.req_type, req_body(cfg_shadow.video_chan, 32'hFFFF_FFFF));
        send_frame(cfg_shadow.req_type, req_body(cfg_shadow.video_chan ^ 8'h80, $urandom));
        send_beat(ACT_POP, 8'h00);
        send_beat(ACT_POP, 8'h00);
        // One more request than the queue holds, then empty it and one more.
        for (int i = 0; i <= QD; i++)
            send_frame(cfg_shadow.req_type, req_body(cfg_shadow.video_chan, $urandom));
        for (int i = 0; i <= QD; i++)
            send_beat(ACT_POP, 8'h00);
    endtask

    // A short length limit keeps the longest legal frame small.
    task automatic test_framing_errors();
        load_settings(8'h00, 8'h01, 8'h02, 8'h00, 16'd1, 16'd24);
        send_header(cfg_shadow.magic, 8'h5A, 16'd0);
        send_header(cfg_shadow.magic, cfg_shadow.hs_type, 16'd0);
        send_frame(cfg_shadow.req_type, random_bytes(4));
        send_frame(cfg_shadow.hs_type, random_bytes(12));
        send_frame(8'h5A, random_bytes(int'(cfg_shadow.max_payload)));
        send_header(cfg_shadow.magic ^ 8'hFF, cfg_shadow.hs_type, 16'd4);
        send_beat(ACT_OPEN, 8'h00);
        send_header(cfg_shadow.magic, 8'h5A, cfg_shadow.max_payload + 16'd1);
        send_beat(ACT_OPEN, 8'h00);
    endtask

    task automatic test_register_extremes();
        load_settings(8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000);
        run_traffic(100);
        load_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        run_traffic(100);
    endtask

    // Runs with no idling on either side.
    task automatic test_back_to_back();
        load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      16'($urandom), 16'($urandom_range(12, 200)));
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        run_traffic(250);
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
    endtask

    task automatic test_random_settings();
        repeat (2)
        begin
            load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          16'($urandom), 16'($urandom_range(12, 65535)));
            run_traffic(190);
        end
        load_settings(8'h00, 8'h01, 8'h02, 8'h00, 16'd1, 16'd1024);
        run_traffic(190);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        reset_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_closed_link();
        test_handshakes();
        test_request_queue();
        test_framing_errors();
        test_register_extremes();
        test_back_to_back();
        test_random_settings();

        drain_results();
        repeat (8) @(posedge clk);
        $display("Covered %0d input beats and %0d result beats over %0d register settings,",
                 beats_sent, results_seen, settings_loaded);
        $display("with closed-link actions, framing errors, a full queue and a stall-free run.");
        if (fail_count == 0)
            $display("framed_command_receiver: match");
        else
            $display("framed_command_receiver: mismatch");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("framed_command_receiver: mismatch");
        $finish;
    end

endmodule
